>>> sv/min_key_priority_queue_core_assert.svh
// Assertion macros used by the priority queue port checker.
`ifndef MIN_KEY_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define MIN_KEY_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define MKPQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mkpq assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define MKPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mkpq assertion failed");

`endif

>>> sv/mkpq_pkg.sv
// Shared types and constants of the minimum-key priority queue.
package mkpq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned DATA_W   = 16;

  typedef enum logic {
    CMD_INSERT  = 1'b0,
    CMD_EXTRACT = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  localparam logic signed [DATA_W-1:0] NO_TAG = -16'sd1;

  // One queue entry as held by a cell.
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] tag;
  } entry_t;

  // Operation broadcast to every cell in a cycle.
  typedef struct packed {
    logic                     ins;
    logic                     ext;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] tag;
  } cell_ctrl_t;

endpackage

>>> sv/mkpq_cell.sv
// One cell of the sorted queue row: holds an entry and trades with its neighbors.
module mkpq_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mkpq_pkg::cell_ctrl_t ctrl_i,
  input  mkpq_pkg::entry_t left_i,
  input  logic             left_ge_i,
  input  mkpq_pkg::entry_t right_i,
  output mkpq_pkg::entry_t entry_o,
  output logic             ge_o
);
  import mkpq_pkg::*;

  logic                     valid_q, valid_d;
  logic signed [DATA_W-1:0] key_q, key_d;
  logic signed [DATA_W-1:0] tag_q, tag_d;

  // Empty cells count as larger than any key, so the new entry lands in front.
  assign ge_o = !valid_q || (key_q >= ctrl_i.key);

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    tag_d   = tag_q;
    if (ctrl_i.ext) begin
      valid_d = right_i.valid;
      key_d   = right_i.key;
      tag_d   = right_i.tag;
    end else if (ctrl_i.ins && ge_o) begin
      if (left_ge_i) begin
        valid_d = left_i.valid;
        key_d   = left_i.key;
        tag_d   = left_i.tag;
      end else begin
        valid_d = 1'b1;
        key_d   = ctrl_i.key;
        tag_d   = ctrl_i.tag;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
  end

  assign entry_o = '{valid: valid_q, key: key_q, tag: tag_q};

endmodule

>>> sv/min_key_priority_queue_core.sv
// Top level of the minimum-key priority queue: cell row plus result register.
//
// A queue of up to CAPACITY (tag, key) pairs kept sorted in a row of cells,
// smallest key at cell 0 and, among equal keys, the newest entry first. The
// block takes one command beat per clock: every cell compares its key with
// the incoming key in parallel and either holds, takes the new entry, or
// takes its neighbor's entry, so an insert or an extract completes in the
// cycle it is accepted and the next beat may follow in the very next cycle.
// The result beat (status, tag_out) is registered in an output register
// and appears in the cycle after acceptance; while that register holds a
// stalled beat the input is stalled too. Inserting into a full queue
// returns status full and stores nothing; extracting from an empty queue
// returns status empty. tag_out is -1 except on a successful extract. No
// clearing pass is needed after reset: only the cell and output valid bits are reset.
module min_key_priority_queue_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic signed [15:0] tag_i,
  input  logic signed [15:0] key_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic signed [15:0] tag_out_o
);
  import mkpq_pkg::*;

  entry_t                cells   [CAPACITY];
  logic [CAPACITY-1:0]   ge;
  cell_ctrl_t            ctrl;

  logic                  in_fire;
  logic                  full, empty;
  logic                  is_ext;

  logic                  out_valid_q, out_valid_d;
  status_e               status_q, status_d;
  logic signed [DATA_W-1:0] tag_q, tag_d;

  // Accept a new beat whenever the result register is free or drains now.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  // The row is a sorted prefix: last cell valid means full, first empty means empty.
  assign full   = cells[CAPACITY-1].valid;
  assign empty  = !cells[0].valid;
  assign is_ext = (cmd_i == CMD_EXTRACT);

  always_comb begin
    ctrl.ins = in_fire && !is_ext && !full;
    ctrl.ext = in_fire && is_ext && !empty;
    ctrl.key = key_i;
    ctrl.tag = tag_i;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_ge;

    if (i == 0) begin : g_head
      // Nothing sits left of the head: it takes the new entry when it moves.
      assign left_e  = '0;
      assign left_ge = 1'b0;
    end else begin : g_body
      assign left_e  = cells[i-1];
      assign left_ge = ge[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      // Drop in an empty entry at the tail on extract.
      assign right_e = '0;
    end else begin : g_mid
      assign right_e = cells[i+1];
    end

    mkpq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .left_i    (left_e),
      .left_ge_i (left_ge),
      .right_i   (right_e),
      .entry_o   (cells[i]),
      .ge_o      (ge[i])
    );
  end

  // Build the result beat; the head cell is the minimum on extract.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    tag_d       = tag_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
      tag_d       = NO_TAG;
      if (!is_ext) begin
        status_d = full ? ST_FULL : ST_OK;
      end else if (empty) begin
        status_d = ST_EMPTY;
      end else begin
        status_d = ST_OK;
        tag_d    = cells[0].tag;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the payload while stalled; it changes only on an accepted beat.
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    tag_q    <= tag_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign tag_out_o   = tag_q;

endmodule

>>> sv/mkpq_checker.sv
// Port-level checker for the priority queue, bound to the top level.
`include "min_key_priority_queue_core_assert.svh"

module mkpq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic signed [15:0] tag_out_o
);
  import mkpq_pkg::*;

  logic in_fire;
  logic out_held;
  logic out_err;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_held = out_valid_o && out_stall_i;
  assign out_err  = out_valid_o && (status_o == ST_FULL || status_o == ST_EMPTY);

  // A stalled result beat holds.
  `MKPQ_ASSERT_NEXT(a_out_hold, out_held, out_valid_o && $stable(status_o) && $stable(tag_out_o))

  // Never take a beat while a stalled result occupies the output register.
  `MKPQ_ASSERT_IMPL(a_no_overrun, out_held, in_stall_o)

  // Every accepted beat yields a result in the next cycle.
  `MKPQ_ASSERT_NEXT(a_one_result, in_fire, out_valid_o)

  // Full and empty responses carry no tag.
  `MKPQ_ASSERT_IMPL(a_err_no_tag, out_err, tag_out_o == NO_TAG)

endmodule

bind min_key_priority_queue_core mkpq_checker u_mkpq_checker (.*);

>>> tb/min_key_priority_queue_core_checker.sv
`timescale 1ns / 1ps
// Checker for the priority queue: mirrors the queue, predicts each result beat and compares.
module min_key_priority_queue_core_checker
  import mkpq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic                     cmd_i,
  input  logic signed [DATA_W-1:0] tag_i,
  input  logic signed [DATA_W-1:0] key_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic [1:0]               status_i,
  input  logic signed [DATA_W-1:0] tag_out_i,
  output int unsigned              pending_o,
  output int unsigned              fail_count_o
);

  typedef struct packed {
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] tag;
  } held_entry_t;

  typedef struct packed {
    status_e                  status;
    logic signed [DATA_W-1:0] tag_out;
  } queue_result_t;

  held_entry_t   held_entries[$];  // insertion order, oldest first
  queue_result_t results_due[$];

  // Apply one command to the mirrored queue and return the result it causes.
  function automatic queue_result_t apply_queue_command(input cmd_e                     cmd,
                                                        input logic signed [DATA_W-1:0] new_tag,
                                                        input logic signed [DATA_W-1:0] new_key);
    queue_result_t res;
    int            best;
    int            i;
    res.status  = ST_OK;
    res.tag_out = NO_TAG;
    if (cmd == CMD_INSERT) begin
      if (held_entries.size() >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        held_entries.push_back('{key: new_key, tag: new_tag});
      end
    end else if (held_entries.size() == 0) begin
      res.status = ST_EMPTY;
    end else begin
      // Walk newest to oldest; only a strictly smaller key takes over, so ties go newest.
      best = held_entries.size() - 1;
      for (i = best - 1; i >= 0; i--) begin
        if ($signed(held_entries[i].key) < $signed(held_entries[best].key)) best = i;
      end
      res.tag_out = held_entries[best].tag;
      held_entries.delete(best);
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    queue_result_t expected;
    if (!rst_ni) begin
      held_entries.delete();
      results_due.delete();
      pending_o <= 0;
      fail_count_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        results_due.push_back(apply_queue_command(cmd_e'(cmd_i), tag_i, key_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (results_due.size() == 0) begin
          $error("result beat with none expected: status %0d tag_out %0d",
                 status_i, tag_out_i);
          fail_count_o++;
        end else begin
          expected = results_due.pop_front();
          if (status_i !== expected.status) begin
            $error("status: expected %0d, got %0d", expected.status, status_i);
            fail_count_o++;
          end
          if (tag_out_i !== expected.tag_out) begin
            $error("tag_out: expected %0d, got %0d", $signed(expected.tag_out), tag_out_i);
            fail_count_o++;
          end
        end
      end
      pending_o <= results_due.size();
    end
  end

endmodule

>>> tb/min_key_priority_queue_core_tb.sv
`timescale 1ns / 1ps
// Testbench top: drives command beats and result stalls into the queue and gives the verdict.
module min_key_priority_queue_core_tb;
  import mkpq_pkg::*;

  localparam int unsigned BEATS_PER_PHASE = 213;
  localparam int unsigned STALL_LIMIT     = 2000;  // cycles without any beat
  localparam int unsigned DRAIN_CYCLES    = 8;

  // Idle and stall percentages per random phase: none, sender, receiver, both.
  localparam int unsigned SEND_IDLE  [4] = '{0, 66, 0, 18};
  localparam int unsigned RECV_STALL [4] = '{0, 0, 66, 18};

  // Directed fill: extreme keys, ties among equal keys, extreme tags.
  localparam logic signed [15:0] FILL_KEY [16] = '{
    -16'sd32768, 16'sd32767, 16'sd0, 16'sd0, -16'sd1, 16'sd32767, -16'sd32768, 16'sd5,
    16'sd1, -16'sd2, 16'sd0, 16'sd100, -16'sd32768, 16'sd7, 16'sd32767, -16'sd1};
  localparam logic signed [15:0] FILL_TAG [16] = '{
    16'sd32767, -16'sd32768, 16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5, 16'sd0,
    16'sd6, 16'sd7, 16'sd8, 16'sd9, -16'sd2, 16'sd10, 16'sd11, 16'sh5AA5};

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic               cmd_i       = 1'b0;
  logic signed [15:0] tag_i       = '0;
  logic signed [15:0] key_i       = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         status_o;
  logic signed [15:0] tag_out_o;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned results_pending;
  int unsigned mismatch_count;

  min_key_priority_queue_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .tag_i       (tag_i),
    .key_i       (key_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .tag_out_o   (tag_out_o)
  );

  min_key_priority_queue_core_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .cmd_i        (cmd_i),
    .tag_i        (tag_i),
    .key_i        (key_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_i     (status_o),
    .tag_out_i    (tag_out_o),
    .pending_o    (results_pending),
    .fail_count_o (mismatch_count)
  );

  always #10 clk_i = ~clk_i;

  // Stall the result channel at the rate the current phase asks for.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: end the run if neither channel moves a beat for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one command beat, after a random idle gap, and hold it until accepted.
  // Valid is raised without regard to the stall; the payload holds while stalled.
  task automatic send_beat(input cmd_e cmd, input logic signed [15:0] tag,
                           input logic signed [15:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    tag_i      <= tag;
    key_i      <= key;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Keys: a narrow band to force ties, the extremes, or anything at all.
  function automatic logic signed [15:0] pick_key();
    case ($urandom_range(3))
      0: return 16'($urandom_range(6)) - 16'sd3;
      1: begin
        case ($urandom_range(3))
          0:       return -16'sd32768;
          1:       return 16'sd32767;
          2:       return 16'sd0;
          default: return -16'sd1;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned insert_pct;
    int unsigned phase;
    int unsigned n;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extract from empty, fill to capacity, refuse one more, then drain part way.
    // Tag and key on the extracts carry extreme values that the queue must ignore.
    send_beat(CMD_EXTRACT, 16'sh7FFF, -16'sd32768);
    for (n = 0; n < CAPACITY; n++) send_beat(CMD_INSERT, FILL_TAG[n], FILL_KEY[n]);
    send_beat(CMD_INSERT, 16'sh1234, -16'sd32768);
    for (n = 0; n < 7; n++) begin
      send_beat(CMD_EXTRACT, n[0] ? -16'sd32768 : 16'sd32767, n[0] ? 16'sd32767 : -16'sd32768);
    end

    // Random phases. The insert bias shifts every few dozen beats so the queue
    // swings between full and empty and both refusals keep happening.
    insert_pct = 50;
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = SEND_IDLE[phase];
      recv_stall_pct = RECV_STALL[phase];
      for (n = 0; n < BEATS_PER_PHASE; n++) begin
        if (n % 40 == 0) begin
          case ($urandom_range(2))
            0:       insert_pct = 80;
            1:       insert_pct = 25;
            default: insert_pct = 55;
          endcase
        end
        send_beat(($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_EXTRACT,
                  16'($urandom), pick_key());
      end
    end

    // Drop valid, let the checker see the last beat, then wait out every result.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/mkpq_pkg.sv
sv/mkpq_cell.sv
sv/min_key_priority_queue_core.sv
sv/mkpq_checker.sv
tb/min_key_priority_queue_core_checker.sv
tb/min_key_priority_queue_core_tb.sv
